>>> hdl/lic_pkg.sv
// Package with shared types and constants for the line intersection block.
`timescale 1ns / 1ps
package lic_pkg;

  // Divider constants: magnitudes of the numerators and of the determinant.
  localparam int MagW   = 32;
  localparam int FracW  = 16;
  localparam int DivNW  = MagW + FracW;   // dividend width after the Q16.16 shift
  localparam int QuotW  = 33;             // quotient bits produced per item
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);
  localparam logic [31:0] TolReset = 32'd1;

  // Register index of the tolerance register on the APB port.
  localparam logic RegTolerance = 1'b0;

  typedef struct packed {
    logic signed [15:0] first_a;
    logic signed [15:0] first_b;
    logic signed [15:0] first_c;
    logic signed [15:0] second_a;
    logic signed [15:0] second_b;
    logic signed [15:0] second_c;
  } in_item_t;

  typedef struct packed {
    logic               point_valid;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
    logic               saturated;
  } out_item_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic            pv;
    logic            neg_x;
    logic            neg_y;
    logic [MagW-1:0] num_x;
    logic [MagW-1:0] num_y;
    logic [MagW-1:0] den;
  } lic_job_t;

  // Queue status seen by front and back.
  typedef struct packed {
    logic empty;
    logic full;
  } lic_qstat_t;

endpackage

>>> hdl/lic_front.sv
// Front part: forms the cross products, the determinant and classifies the item.
`timescale 1ns / 1ps
module lic_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lic_pkg::in_item_t in_item,
  input  logic [31:0]       tolerance,
  input  lic_pkg::lic_qstat_t qstat,
  output logic              push,
  output lic_pkg::lic_job_t push_job
);
  import lic_pkg::*;

  logic               f1_valid_r;
  logic signed [31:0] p_a1b2_r, p_a2b1_r, p_c1b2_r, p_c2b1_r, p_a1c2_r, p_a2c1_r;
  logic               f2_valid_r;
  lic_job_t           f2_job_r;
  lic_job_t           f2_job_nxt;
  logic               advance;
  logic signed [32:0] det, nx, ny;
  logic [32:0]        det_mag, nx_mag, ny_mag;

  assign advance  = !(f2_valid_r && qstat.full);
  assign in_stall = !advance;
  assign push     = f2_valid_r && !qstat.full;
  assign push_job = f2_job_r;

  always_comb begin
    det = 33'(p_a1b2_r) - 33'(p_a2b1_r);
    nx  = 33'(p_c2b1_r) - 33'(p_c1b2_r);
    ny  = 33'(p_a2c1_r) - 33'(p_a1c2_r);
    det_mag = det[32] ? 33'(-det) : 33'(det);
    nx_mag  = nx[32]  ? 33'(-nx)  : 33'(nx);
    ny_mag  = ny[32]  ? 33'(-ny)  : 33'(ny);
    f2_job_nxt.pv    = (det != 33'sd0) && (det_mag >= {1'b0, tolerance});
    f2_job_nxt.neg_x = nx[32] ^ det[32];
    f2_job_nxt.neg_y = ny[32] ^ det[32];
    f2_job_nxt.num_x = nx_mag[MagW-1:0];
    f2_job_nxt.num_y = ny_mag[MagW-1:0];
    f2_job_nxt.den   = det_mag[MagW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else if (advance) begin
      f1_valid_r <= in_valid;
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_a1b2_r <= in_item.first_a  * in_item.second_b;
      p_a2b1_r <= in_item.second_a * in_item.first_b;
      p_c1b2_r <= in_item.first_c  * in_item.second_b;
      p_c2b1_r <= in_item.second_c * in_item.first_b;
      p_a1c2_r <= in_item.first_a  * in_item.second_c;
      p_a2c1_r <= in_item.second_a * in_item.first_c;
      f2_job_r <= f2_job_nxt;
    end
  end

endmodule

>>> hdl/lic_queue.sv
// Short queue that decouples the front part from the divider pipeline.
`timescale 1ns / 1ps
module lic_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lic_pkg::lic_job_t   push_job,
  input  logic                pop,
  output lic_pkg::lic_job_t   pop_job,
  output lic_pkg::lic_qstat_t qstat
);
  import lic_pkg::*;

  lic_job_t          mem_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0]  count_r;

  assign qstat.empty = (count_r == '0);
  assign qstat.full  = (count_r == QCntW'(QDepth));
  assign pop_job     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

>>> hdl/lic_back.sv
// Back part: pipelined restoring divider, one quotient bit per stage, and saturation.
`timescale 1ns / 1ps
module lic_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lic_pkg::lic_qstat_t qstat,
  input  lic_pkg::lic_job_t   pop_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output lic_pkg::out_item_t  out_item
);
  import lic_pkg::*;

  typedef struct packed {
    logic             pv;
    logic             neg_x;
    logic             neg_y;
    logic             ovf_x;
    logic             ovf_y;
    logic [DivNW-1:0] rem_x;
    logic [DivNW-1:0] rem_y;
    logic [QuotW-1:0] q_x;
    logic [QuotW-1:0] q_y;
    logic [MagW-1:0]  den;
  } stage_t;

  logic       vld_r [QuotW+1];
  stage_t     st_r  [QuotW+1];
  logic       out_valid_r;
  out_item_t  out_item_r;
  logic       advance;
  stage_t     st0_nxt;
  out_item_t  out_nxt;

  assign advance   = !(out_valid_r && out_stall);
  assign pop       = advance && !qstat.empty;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The quotient has more than QuotW bits exactly when n >= den * 2^QuotW.
  function automatic logic too_big(input logic [DivNW-1:0] n, input logic [MagW-1:0] d);
    return {{(MagW+QuotW-DivNW){1'b0}}, n} >= {d, {QuotW{1'b0}}};
  endfunction

  always_comb begin
    st0_nxt.pv    = pop_job.pv;
    st0_nxt.neg_x = pop_job.neg_x;
    st0_nxt.neg_y = pop_job.neg_y;
    st0_nxt.rem_x = {pop_job.num_x, {FracW{1'b0}}};
    st0_nxt.rem_y = {pop_job.num_y, {FracW{1'b0}}};
    st0_nxt.ovf_x = too_big(st0_nxt.rem_x, pop_job.den);
    st0_nxt.ovf_y = too_big(st0_nxt.rem_y, pop_job.den);
    st0_nxt.q_x   = '0;
    st0_nxt.q_y   = '0;
    st0_nxt.den   = pop_job.den;
  end

  // One restoring step per stage; stage s decides quotient bit QuotW-1-s.
  always_ff @(posedge clk) begin
    if (advance) begin
      st_r[0] <= st0_nxt;
      for (int s = 0; s < QuotW; s++) begin
        logic [MagW+QuotW-1:0] dsh;
        logic [MagW+QuotW-1:0] rx, ry;
        stage_t                nx;
        dsh = {{QuotW{1'b0}}, st_r[s].den} << (QuotW - 1 - s);
        rx  = {{(MagW+QuotW-DivNW){1'b0}}, st_r[s].rem_x};
        ry  = {{(MagW+QuotW-DivNW){1'b0}}, st_r[s].rem_y};
        nx  = st_r[s];
        if (rx >= dsh) begin
          nx.rem_x = DivNW'(rx - dsh);
          nx.q_x[QuotW-1-s] = 1'b1;
        end
        if (ry >= dsh) begin
          nx.rem_y = DivNW'(ry - dsh);
          nx.q_y[QuotW-1-s] = 1'b1;
        end
        st_r[s+1] <= nx;
      end
      out_item_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= QuotW; s++) vld_r[s] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      vld_r[0] <= !qstat.empty;
      for (int s = 0; s < QuotW; s++) vld_r[s+1] <= vld_r[s];
      out_valid_r <= vld_r[QuotW];
    end
  end

  function automatic logic [32:0] sat_q(input logic neg, input logic ovf,
                                        input logic [QuotW-1:0] q);
    logic        clip;
    logic [31:0] val;
    if (neg) begin
      clip = ovf || (q > 33'h080000000);
      val  = clip ? 32'h80000000 : 32'(-q[31:0]);
    end else begin
      clip = ovf || (q[32:31] != 2'b00);
      val  = clip ? 32'h7FFFFFFF : q[31:0];
    end
    return {clip, val};
  endfunction

  always_comb begin
    logic [32:0] rx, ry;
    rx = sat_q(st_r[QuotW].neg_x, st_r[QuotW].ovf_x, st_r[QuotW].q_x);
    ry = sat_q(st_r[QuotW].neg_y, st_r[QuotW].ovf_y, st_r[QuotW].q_y);
    if (st_r[QuotW].pv) begin
      out_nxt.point_valid = 1'b1;
      out_nxt.cross_x     = rx[31:0];
      out_nxt.cross_y     = ry[31:0];
      out_nxt.saturated   = rx[32] | ry[32];
    end else begin
      out_nxt = '0;
    end
  end

endmodule

>>> hdl/line_intersection_cramer.sv
// Top level of the line intersection block with its configuration register.
`timescale 1ns / 1ps
// Intersection of two lines A*x + B*y + C = 0 by Cramer's rule.
// The input channel (in_valid, in_stall, in_item) carries one item: the six
// signed Q8.8 coefficients of a pair of lines. The output channel (out_valid,
// out_stall, out_item) returns one item per input item, in order: a valid
// flag, x and y in signed Q16.16 and a flag set when a coordinate clipped.
// Throughput is one item per cycle when nothing stalls. From acceptance to
// out_valid, two front stages form the products and the determinant, the
// item passes through the queue, then 34 divider stages (one quotient bit
// each, plus the overflow check) and the output register.
// The APB port holds the parallel tolerance at address 0 (reset value 1);
// write it only while the block is idle.
// While out_valid and out_stall are high the output item holds and the divider
// pipeline freezes; the four-entry queue then fills, and in_stall rises.
// Synchronous reset empties the pipeline and the queue and restores the
// tolerance; no result is pending after reset.
module line_intersection_cramer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lic_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output lic_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lic_pkg::*;

  logic        [31:0] tol_r;
  lic_qstat_t         qstat;
  lic_job_t           push_job, pop_job;
  logic               push, pop;

  // Register decode looks at the word address only.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegTolerance) ? tol_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TolReset;
    end else if (psel && penable && pwrite && (paddr[2] == RegTolerance)) begin
      tol_r <= pwdata;
    end
  end

  lic_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .tolerance(tol_r),
    .qstat    (qstat),
    .push     (push),
    .push_job (push_job)
  );

  lic_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .pop_job (pop_job),
    .qstat   (qstat)
  );

  lic_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .qstat    (qstat),
    .pop_job  (pop_job),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

>>> hdl/lic_checker.sv
// Port-level checker for the line intersection block and its bind.
`timescale 1ns / 1ps
module lic_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input lic_pkg::out_item_t out_item,
  input logic               pready
);
  import lic_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output item changed");

  a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.point_valid |->
      out_item.cross_x == 32'sd0 && out_item.cross_y == 32'sd0 && !out_item.saturated)
    else $error("parallel result not cleared");

  a_sat_needs_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.saturated |-> out_item.point_valid)
    else $error("saturated flag on a parallel result");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind line_intersection_cramer lic_checker u_lic_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_item (out_item),
  .pready   (pready)
);

>>> test/tb.sv
// Testbench for the line intersection block: checks every result against a predictor.
`timescale 1ns / 1ps
module tb;
  import lic_pkg::*;

  // Clock, reset and block ports.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Pending line pairs waiting for the driver, and predicted intersection points.
  in_item_t  pair_queue[$];
  out_item_t point_queue[$];
  logic [31:0] tolerance_shadow;
  int          fail_count = 0;
  // Idle percentages of the sender and of the receiver for the current phase.
  int          send_idle_pct = 12;
  int          recv_idle_pct = 57;

  line_intersection_cramer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Saturating Q16.16 quotient of num/den with truncation toward zero.
  function automatic logic [31:0] q16_quotient(input longint num, input longint den,
                                               inout logic sat);
    logic [63:0] num_mag;
    logic [63:0] den_mag;
    logic [63:0] quot;
    logic        negative;
    begin
      num_mag  = (num < 0) ? 64'(-num) : 64'(num);
      den_mag  = (den < 0) ? 64'(-den) : 64'(den);
      quot     = (num_mag << 16) / den_mag;
      negative = (num < 0) != (den < 0);
      if (negative) begin
        if (quot > 64'h8000_0000) begin
          quot = 64'h8000_0000;
          sat  = 1'b1;
        end
        return 32'(-quot);
      end
      if (quot > 64'h7FFF_FFFF) begin
        quot = 64'h7FFF_FFFF;
        sat  = 1'b1;
      end
      return quot[31:0];
    end
  endfunction

  // Expected intersection result for one pair of lines.
  function automatic out_item_t intersect_lines(input in_item_t p);
    longint    a1, b1, c1, a2, b2, c2, det, det_mag;
    out_item_t r;
    logic      sat;
    begin
      a1 = p.first_a;  b1 = p.first_b;  c1 = p.first_c;
      a2 = p.second_a; b2 = p.second_b; c2 = p.second_c;
      det     = a1 * b2 - a2 * b1;
      det_mag = (det < 0) ? -det : det;
      r   = '0;
      sat = 1'b0;
      // A zero determinant is always parallel, even with a zero tolerance.
      if (det == 0 || det_mag < longint'(tolerance_shadow)) return r;
      r.point_valid = 1'b1;
      r.cross_x     = q16_quotient(-(c1 * b2 - c2 * b1), det, sat);
      r.cross_y     = q16_quotient(-(a1 * c2 - a2 * c1), det, sat);
      r.saturated   = sat;
      return r;
    end
  endfunction

  // Driver: presents the next pending pair, holding it while stalled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pair_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= pair_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Prediction happens at acceptance, with the tolerance in force at that time.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) point_queue.push_back(intersect_lines(in_item));
  end

  // Monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (point_queue.size() == 0) begin
          $error("unexpected result item %h", out_item);
          fail_count++;
        end else begin
          want = point_queue.pop_front();
          if (out_item.point_valid !== want.point_valid) begin
            $error("point_valid expected %0d actual %0d", want.point_valid,
                   out_item.point_valid);
            fail_count++;
          end
          if (out_item.cross_x !== want.cross_x) begin
            $error("cross_x expected %h actual %h", want.cross_x, out_item.cross_x);
            fail_count++;
          end
          if (out_item.cross_y !== want.cross_y) begin
            $error("cross_y expected %h actual %h", want.cross_y, out_item.cross_y);
            fail_count++;
          end
          if (out_item.saturated !== want.saturated) begin
            $error("saturated expected %0d actual %0d", want.saturated,
                   out_item.saturated);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // APB write of the tolerance register: setup cycle, then access cycle.
  task automatic write_tolerance(input logic [31:0] value);
    begin
      @(posedge clk);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      paddr   <= {RegTolerance, 2'b00};
      pwdata  <= value;
      penable <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      tolerance_shadow = value;
    end
  endtask

  // Waits until every queued pair is accepted and every result has come back.
  task automatic drain;
    begin
      while (pair_queue.size() > 0 || in_valid || point_queue.size() > 0) @(posedge clk);
      repeat (40) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_coef();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 64)) - 32);
      3: return 16'(int'($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_pair();
    in_item_t p;
    logic signed [15:0] k;
    begin
      p.first_a  = rand_coef(); p.first_b  = rand_coef(); p.first_c  = rand_coef();
      p.second_a = rand_coef(); p.second_b = rand_coef(); p.second_c = rand_coef();
      // Some pairs are made parallel by scaling the first line.
      if ($urandom_range(9) == 0) begin
        k = 16'(int'($urandom_range(0, 6)) - 3);
        p.first_a  = 16'(int'($urandom_range(0, 200)) - 100);
        p.first_b  = 16'(int'($urandom_range(0, 200)) - 100);
        p.second_a = p.first_a * k;
        p.second_b = p.first_b * k;
      end
      return p;
    end
  endfunction

  function automatic in_item_t make_pair(input logic [15:0] a1, b1, c1, a2, b2, c2);
    in_item_t p;
    begin
      p.first_a = a1; p.first_b = b1; p.first_c = c1;
      p.second_a = a2; p.second_b = b2; p.second_c = c2;
      return p;
    end
  endfunction

  // Stimulus: directed pairs, then random phases under several tolerances.
  initial begin
    logic [31:0] tol_set[5];
    tolerance_shadow = TolReset;
    tol_set = '{32'd0, 32'd1, 32'h0000_0100, 32'h0100_0000, 32'hFFFF_FFFF};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unit axes, parallel, coincident, extremes and saturation.
    pair_queue.push_back(make_pair(16'h0100, 16'h0000, 16'hFF00,
                                   16'h0000, 16'h0100, 16'hFE00));
    pair_queue.push_back(make_pair(16'h0100, 16'h0100, 16'h0100,
                                   16'h0200, 16'h0200, 16'h0300));
    pair_queue.push_back(make_pair(16'h0100, 16'h0200, 16'h0300,
                                   16'h0100, 16'h0200, 16'h0300));
    pair_queue.push_back(make_pair(16'h0000, 16'h0000, 16'h0000,
                                   16'h0000, 16'h0000, 16'h0000));
    pair_queue.push_back(make_pair(16'h8000, 16'h7FFF, 16'h8000,
                                   16'h7FFF, 16'h8000, 16'h7FFF));
    pair_queue.push_back(make_pair(16'h8000, 16'h8000, 16'h7FFF,
                                   16'h8000, 16'h7FFF, 16'h8000));
    pair_queue.push_back(make_pair(16'h0001, 16'h0000, 16'h7FFF,
                                   16'h0000, 16'h0001, 16'h8000));
    pair_queue.push_back(make_pair(16'h0001, 16'h0000, 16'h8000,
                                   16'h0000, 16'h0001, 16'h7FFF));
    pair_queue.push_back(make_pair(16'h0003, 16'h0000, 16'h0001,
                                   16'h0000, 16'hFFFD, 16'hFFFF));
    pair_queue.push_back(make_pair(16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   16'hFFFF, 16'h0001, 16'hFFFF));
    pair_queue.push_back(make_pair(16'h0001, 16'h0000, 16'h0000,
                                   16'h0000, 16'h0001, 16'h0000));
    drain();

    // Zero tolerance: a zero determinant must still read as parallel.
    write_tolerance(32'd0);
    pair_queue.push_back(make_pair(16'h0100, 16'h0100, 16'h0100,
                                   16'h0100, 16'h0100, 16'h0200));
    pair_queue.push_back(make_pair(16'h0001, 16'h0000, 16'h0005,
                                   16'h0000, 16'h0001, 16'h0007));
    drain();

    // Random phases; the idle pattern moves with the phase.
    for (int ph = 0; ph < 15; ph++) begin
      if (ph == 5) begin send_idle_pct = 57; recv_idle_pct = 12; end
      if (ph == 10) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_tolerance((ph % 3 == 2) ? $urandom : tol_set[ph % 5]);
      repeat (106) pair_queue.push_back(rand_pair());
      drain();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
